// ===== src/vrs_pkg.sv =====
// Package for the voxel ray step block: widths, state and command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrs_pkg;
    localparam int POS_FRAC_BITS = 16;
    localparam int T_FRAC        = 16;
    localparam int DIR_FRAC      = 12;
    localparam int DIR_W         = 16;
    localparam int POS_W         = 32;
    localparam int CELL_W        = 16;
    localparam int NUM_W         = 48;  // shifted numerator
    localparam int Q_W           = 48;  // quotient magnitude width
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_DIV_START, ST_DIV_RUN, ST_DIV_DONE,
        ST_SCALE, ST_MUL, ST_ADV, ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;       // take start position
        logic       clr_best;
        logic       div_start;  // begin division for candidate sel
        logic [2:0] cand;       // 0..5: axis*2 + plane
        logic       take_q;     // compare quotient with best
        logic       scale;
        logic [1:0] axis;       // axis for multiply/advance
        logic       mul;
        logic       adv;
        logic       clr_sat;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic skip;             // direction of cand axis is zero
    } t_stat;
endpackage
`default_nettype wire

// ===== src/vrs_if.sv =====
// Valid/ready channel interface for the voxel ray step block.
// Parameterised payload type; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
interface vrs_if #(parameter type T = logic) (input wire i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/vrs_div.sv =====
// Restoring unsigned divider, one quotient bit a cycle.
// Depends on vrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrs_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [vrs_pkg::NUM_W-1:0]     i_num,
    input  wire [vrs_pkg::DIR_W-1:0]     i_den,
    output logic                         o_busy,
    output logic [vrs_pkg::Q_W-1:0]      o_quot
);
    localparam int CW = $clog2(vrs_pkg::NUM_W + 1);
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [vrs_pkg::NUM_W-1:0]   r_q, n_q;
    logic [vrs_pkg::DIR_W:0]     r_rem, n_rem;
    logic [vrs_pkg::DIR_W-1:0]   r_den;
    logic [vrs_pkg::DIR_W+1:0]   w_try;

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        n_rem = r_rem;
        w_try = {r_rem, r_q[vrs_pkg::NUM_W-1]} - {2'b00, r_den};
        if (i_start) begin
            n_cnt = CW'(vrs_pkg::NUM_W);
            n_q   = i_num;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (!w_try[vrs_pkg::DIR_W+1]) begin
                n_rem = w_try[vrs_pkg::DIR_W:0];
                n_q   = {r_q[vrs_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[vrs_pkg::DIR_W-1:0], r_q[vrs_pkg::NUM_W-1]};
                n_q   = {r_q[vrs_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else          r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== src/vrs_datapath.sv =====
// Datapath: position and direction registers, candidate forming, shared
// divider, min select, scale, multiply and saturating advance. Uses vrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrs_datapath #(
    parameter int POS_FRAC_BITS = vrs_pkg::POS_FRAC_BITS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [vrs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [vrs_pkg::DIR_W-1:0]          i_cfg_data,
    input  wire [3*vrs_pkg::POS_W-1:0]        i_start,
    input  vrs_pkg::t_cmd                     i_cmd,
    output vrs_pkg::t_stat                    o_stat,
    output logic [3*vrs_pkg::CELL_W-1:0]      o_cells,
    output logic                              o_sat
);
    localparam int DIV_SHIFT = vrs_pkg::T_FRAC + vrs_pkg::DIR_FRAC - POS_FRAC_BITS;
    localparam int PW = vrs_pkg::POS_W;
    localparam int PRW = PW + vrs_pkg::DIR_W + 1;

    logic signed [vrs_pkg::DIR_W-1:0] r_dir [3];
    logic signed [PW-1:0]             r_pos [3];
    logic [vrs_pkg::Q_W-1:0]          r_best;
    logic                             r_have;
    logic [PW-1:0]                    r_ts;
    logic signed [PRW-1:0]            r_prod;
    logic                             r_sat;

    // candidate operands
    logic [1:0]                 w_ax;
    logic signed [PW-1:0]       w_p;
    logic [PW-1:0]              w_pmag;
    logic signed [PW:0]         w_frac, w_num;
    logic [PW:0]                w_nmag;
    logic signed [vrs_pkg::DIR_W-1:0] w_d;
    logic [vrs_pkg::DIR_W-1:0]  w_dmag;
    logic                       w_qneg;
    logic                       w_busy;
    logic [vrs_pkg::Q_W-1:0]    w_qmag;
    logic [PW-1:0]              w_bx;
    logic [62:0]                w_recip;
    logic [PW-1:0]              w_ts;

    always_comb begin
        w_ax   = i_cmd.cand[2:1];
        w_p    = r_pos[w_ax];
        w_pmag = w_p[PW-1] ? PW'(-w_p) : w_p;
        w_frac = (PW+1)'(w_pmag & PW'((64'd1 << POS_FRAC_BITS) - 1));
        if (w_p[PW-1]) w_frac = -w_frac;
        w_num  = i_cmd.cand[0] ? ((PW+1)'(64'd1 << POS_FRAC_BITS) - w_frac) : -w_frac;
        w_nmag = w_num[PW] ? (PW+1)'(-w_num) : w_num;
        w_d    = r_dir[w_ax];
        w_dmag = w_d[vrs_pkg::DIR_W-1] ? vrs_pkg::DIR_W'(-w_d) : w_d;
        w_qneg = w_num[PW] ^ w_d[vrs_pkg::DIR_W-1];
    end

    vrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (vrs_pkg::NUM_W'(w_nmag) << DIV_SHIFT),
        .i_den   (w_dmag),
        .o_busy  (w_busy),
        .o_quot  (w_qmag)
    );

    assign o_stat = '{div_busy: w_busy, skip: (w_d == '0)};

    // ts = best + floor(best/100) by reciprocal multiply; best stays below 2^30
    always_comb begin
        w_bx    = r_best[PW-1:0];
        w_recip = 63'(w_bx) * 63'(31'd1374389535);
        w_ts    = w_bx + {6'd0, w_recip[62:37]};
    end

    logic signed [PW+1:0]   w_np;
    logic [PRW-1:0]         w_pmag2;
    logic signed [PW+1:0]   w_delta;
    always_comb begin
        w_pmag2 = r_prod[PRW-1] ? PRW'(-r_prod) : r_prod;
        w_pmag2 = w_pmag2 >> DIV_SHIFT;
        w_delta = (PW+2)'(w_pmag2);
        // clamp oversized magnitude well beyond 32-bit range
        if (|(w_pmag2 >> (PW+1))) w_delta = (PW+2)'(64'd1 << PW);
        if (r_prod[PRW-1]) w_delta = -w_delta;
        w_np = (PW+2)'(r_pos[i_cmd.axis]) + w_delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_dir[i] <= '0;
                r_pos[i] <= '0;
            end
            r_have <= 1'b0;
            r_sat  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vrs_pkg::REG_DIR_X: r_dir[0] <= i_cfg_data;
                    vrs_pkg::REG_DIR_Y: r_dir[1] <= i_cfg_data;
                    vrs_pkg::REG_DIR_Z: r_dir[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_sat) r_sat <= 1'b0;
            if (i_cmd.load) begin
                for (int i = 0; i < 3; i++) r_pos[i] <= i_start[i*PW +: PW];
            end
            if (i_cmd.clr_best) r_have <= 1'b0;
            if (i_cmd.take_q && !w_qneg && w_qmag != '0
                && (!r_have || w_qmag < r_best)) begin
                r_best <= w_qmag;
                r_have <= 1'b1;
            end
            if (i_cmd.adv) begin
                if (w_np > (PW+2)'(64'sd2147483647)) begin
                    r_pos[i_cmd.axis] <= {1'b0, {(PW-1){1'b1}}};
                    r_sat <= 1'b1;
                end else if (w_np < -(PW+2)'(64'sd2147483648)) begin
                    r_pos[i_cmd.axis] <= {1'b1, {(PW-1){1'b0}}};
                    r_sat <= 1'b1;
                end else begin
                    r_pos[i_cmd.axis] <= PW'(w_np);
                end
            end
        end
        if (i_cmd.scale) r_ts <= r_have ? w_ts : '0;
        if (i_cmd.mul)   r_prod <= PRW'($signed({1'b0, r_ts})) * PRW'(r_dir[i_cmd.axis]);
    end

    logic [PW-1:0] w_m;
    logic [PW-1:0] w_ip;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_m  = r_pos[i][PW-1] ? PW'(-r_pos[i]) : r_pos[i];
            w_ip = w_m >> POS_FRAC_BITS;
            if (w_ip > 32'd32767)
                o_cells[i*vrs_pkg::CELL_W +: vrs_pkg::CELL_W] =
                    r_pos[i][PW-1] ? 16'h8000 : 16'h7FFF;
            else
                o_cells[i*vrs_pkg::CELL_W +: vrs_pkg::CELL_W] =
                    r_pos[i][PW-1] ? vrs_pkg::CELL_W'(-w_ip) : vrs_pkg::CELL_W'(w_ip);
        end
    end
    assign o_sat = r_sat;
endmodule
`default_nettype wire

// ===== src/vrs_ctrl.sv =====
// Controller state machine: sequences load or up to six divisions, scale,
// and three multiply/advance passes. Uses vrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_kind,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  vrs_pkg::t_stat   i_stat,
    output vrs_pkg::t_cmd    o_cmd
);
    vrs_pkg::t_state r_state, n_state;
    logic [2:0] r_cand, n_cand;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vrs_pkg::ST_IDLE;
            r_cand  <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            r_cand  <= n_cand;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cand  = r_cand;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.cand = r_cand;
        o_cmd.axis = r_axis;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            vrs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.clr_sat = 1'b1;
                    if (i_in_kind) begin
                        o_cmd.load = 1'b1;
                        n_state = vrs_pkg::ST_OUT;
                    end else begin
                        o_cmd.clr_best = 1'b1;
                        n_cand  = '0;
                        n_state = vrs_pkg::ST_DIV_START;
                    end
                end
            end
            vrs_pkg::ST_DIV_START: begin
                if (i_stat.skip) begin
                    n_state = vrs_pkg::ST_DIV_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = vrs_pkg::ST_DIV_RUN;
                end
            end
            vrs_pkg::ST_DIV_RUN: begin
                if (!i_stat.div_busy) begin
                    o_cmd.take_q = 1'b1;
                    n_state = vrs_pkg::ST_DIV_DONE;
                end
            end
            vrs_pkg::ST_DIV_DONE: begin
                if (r_cand == 3'd5) begin
                    n_state = vrs_pkg::ST_SCALE;
                end else begin
                    n_cand  = r_cand + 1'b1;
                    n_state = vrs_pkg::ST_DIV_START;
                end
            end
            vrs_pkg::ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_axis  = '0;
                n_state = vrs_pkg::ST_MUL;
            end
            vrs_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = vrs_pkg::ST_ADV;
            end
            vrs_pkg::ST_ADV: begin
                o_cmd.adv = 1'b1;
                if (r_axis == 2'd2) begin
                    n_state = vrs_pkg::ST_OUT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = vrs_pkg::ST_MUL;
                end
            end
            vrs_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = vrs_pkg::ST_IDLE;
            end
            default: n_state = vrs_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/voxel_ray_step.sv =====
// Channel   Dir  Payload
// in_ch     in   kind, start_x, start_y, start_z
// out_ch    out  cell_x, cell_y, cell_z, saturated
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (dir_x/y/z)
// Load item: transfer in, then result. Step item: for each candidate plane on an
// axis with nonzero direction, start, 48 quotient bits on the shared bit-serial
// divider, compare and next; on a zero axis the division is skipped; then scale,
// three multiply/advance passes and the result.
// One item at a time; the result is held while the receiver stalls. Reset clears
// position, direction and control. Depends on vrs_pkg, vrs_ctrl, vrs_datapath.
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_step #(
    parameter int POS_FRAC_BITS = vrs_pkg::POS_FRAC_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [vrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [vrs_pkg::DIR_W-1:0]      i_cfg_data,
    input  wire                           i_kind,
    input  wire [vrs_pkg::POS_W-1:0]      i_start_x,
    input  wire [vrs_pkg::POS_W-1:0]      i_start_y,
    input  wire [vrs_pkg::POS_W-1:0]      i_start_z,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    output logic [vrs_pkg::CELL_W-1:0]    o_cell_x,
    output logic [vrs_pkg::CELL_W-1:0]    o_cell_y,
    output logic [vrs_pkg::CELL_W-1:0]    o_cell_z,
    output logic                          o_saturated,
    output logic                          o_out_valid,
    input  wire                           i_out_ready
);
    vrs_pkg::t_cmd  w_cmd;
    vrs_pkg::t_stat w_stat;
    logic [3*vrs_pkg::CELL_W-1:0] w_cells;

    vrs_ctrl u_ctrl (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_in_valid (i_in_valid), .i_in_kind (i_kind), .o_in_ready (o_in_ready),
        .o_out_valid (o_out_valid), .i_out_ready (i_out_ready),
        .i_stat (w_stat), .o_cmd (w_cmd)
    );

    vrs_datapath #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_cfg_we (i_cfg_we), .i_cfg_idx (i_cfg_idx), .i_cfg_data (i_cfg_data),
        .i_start ({i_start_z, i_start_y, i_start_x}),
        .i_cmd (w_cmd), .o_stat (w_stat), .o_cells (w_cells), .o_sat (o_saturated)
    );

    assign o_cell_x = w_cells[0 +: vrs_pkg::CELL_W];
    assign o_cell_y = w_cells[vrs_pkg::CELL_W +: vrs_pkg::CELL_W];
    assign o_cell_z = w_cells[2*vrs_pkg::CELL_W +: vrs_pkg::CELL_W];

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_x))
        else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// ===== sim/vrs_chk.sv =====
// Checker for voxel_ray_step: watches the input, output and register-write ports,
// predicts each result from its own copy of position and direction, and compares.
// Depends on vrs_pkg and vrs_if.
`timescale 1ns / 1ps
`default_nettype none
module vrs_chk (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    vrs_if                               in_ch,
    vrs_if                               out_ch,
    input  wire                          i_cfg_we,
    input  wire [vrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [vrs_pkg::DIR_W-1:0]     i_cfg_data,
    output int                           o_errors,
    output int                           o_pending
);
    localparam int SHIFT = vrs_pkg::T_FRAC + vrs_pkg::DIR_FRAC - vrs_pkg::POS_FRAC_BITS;
    localparam longint ONE = longint'(1) << vrs_pkg::POS_FRAC_BITS;

    longint    dir_q [3];
    longint    pos_q [3];
    logic [48:0] cells_due [$];

    function automatic longint frac_part(longint p);
        longint fm;
        fm = (p < 0 ? -p : p) & (ONE - 1);
        return p < 0 ? -fm : fm;
    endfunction

    function automatic logic [15:0] cell_part(longint p);
        longint ip;
        ip = (p < 0 ? -p : p) >>> vrs_pkg::POS_FRAC_BITS;
        if (p < 0) ip = -ip;
        if (ip > 32767) ip = 32767;
        if (ip < -32768) ip = -32768;
        return ip[15:0];
    endfunction

    // Updates the tracked position and returns {cell_x, cell_y, cell_z, saturated}
    function automatic logic [48:0] trace_cell(logic [96:0] item);
        longint best, q, num, ts, prod, m, np;
        logic   have, sat;
        best = 0; have = 1'b0; sat = 1'b0;
        if (item[96]) begin
            pos_q[0] = longint'($signed(item[95:64]));
            pos_q[1] = longint'($signed(item[63:32]));
            pos_q[2] = longint'($signed(item[31:0]));
        end else begin
            for (int a = 0; a < 3; a++) begin
                if (dir_q[a] != 0) begin
                    for (int pl = 0; pl < 2; pl++) begin
                        num = (pl == 0 ? 0 : ONE) - frac_part(pos_q[a]);
                        q = (num * (longint'(1) << SHIFT)) / dir_q[a];
                        if (q > 0 && (!have || q < best)) begin
                            best = q;
                            have = 1'b1;
                        end
                    end
                end
            end
            ts = have ? (best * 101) / 100 : 0;
            for (int a = 0; a < 3; a++) begin
                prod = ts * dir_q[a];
                m = (prod < 0 ? -prod : prod) >>> SHIFT;
                np = pos_q[a] + (prod < 0 ? -m : m);
                if (np > 64'sd2147483647) begin
                    np = 64'sd2147483647; sat = 1'b1;
                end
                if (np < -64'sd2147483648) begin
                    np = -64'sd2147483648; sat = 1'b1;
                end
                pos_q[a] = np;
            end
        end
        return {cell_part(pos_q[0]), cell_part(pos_q[1]), cell_part(pos_q[2]), sat};
    endfunction

    always @(posedge i_clk) begin
        logic [48:0] want;
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                dir_q[a] = 0;
                pos_q[a] = 0;
            end
            cells_due.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vrs_pkg::REG_DIR_X: dir_q[0] = longint'($signed(i_cfg_data));
                    vrs_pkg::REG_DIR_Y: dir_q[1] = longint'($signed(i_cfg_data));
                    vrs_pkg::REG_DIR_Z: dir_q[2] = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                cells_due.push_back(trace_cell(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (cells_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result transfer: %h", out_ch.data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = cells_due.pop_front();
                    if (want !== out_ch.data) begin
                        if (o_errors < 10)
                            $display({"cell mismatch: exp x=%0d y=%0d z=%0d sat=%b,",
                                      " got x=%0d y=%0d z=%0d sat=%b"},
                                $signed(want[48:33]), $signed(want[32:17]),
                                $signed(want[16:1]), want[0],
                                $signed(out_ch.data[48:33]),
                                $signed(out_ch.data[32:17]),
                                $signed(out_ch.data[16:1]), out_ch.data[0]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= cells_due.size();
        end
    end
endmodule
`default_nettype wire

// ===== sim/voxel_ray_step_tb.sv =====
// Top of the voxel_ray_step testbench: clock, reset, stimulus and verdict.
// Depends on vrs_pkg, vrs_if, vrs_chk and the voxel_ray_step RTL.
`timescale 1ns / 1ps
`default_nettype none
module voxel_ray_step_tb;
    typedef enum int { PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH } t_phase;

    // no register at this index
    localparam logic [vrs_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [vrs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [vrs_pkg::DIR_W-1:0] i_cfg_data = '0;
    t_phase phase = PH_FREE;
    int errors, pending;
    int src_idle_pct, snk_stall_pct;
    longint cycles = 0;
    int stall_left = 0;
    logic pressed = 1'b0;
    logic in_random = 1'b0;
    wire [vrs_pkg::CELL_W-1:0] w_cx, w_cy, w_cz;
    wire w_sat, w_out_valid;

    vrs_if #(.T(logic [96:0])) in_ch (i_clk);
    vrs_if #(.T(logic [48:0])) out_ch (i_clk);

    assign out_ch.data  = {w_cx, w_cy, w_cz, w_sat};
    assign out_ch.valid = w_out_valid;

    voxel_ray_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_kind(in_ch.data[96]), .i_start_x(in_ch.data[95:64]),
        .i_start_y(in_ch.data[63:32]), .i_start_z(in_ch.data[31:0]),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .o_cell_x(w_cx), .o_cell_y(w_cy), .o_cell_z(w_cz), .o_saturated(w_sat),
        .o_out_valid(w_out_valid), .i_out_ready(out_ch.ready)
    );

    vrs_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always_comb begin
        src_idle_pct  = (phase == PH_SRC_IDLE) ? 83 : (phase == PH_BOTH) ? 36 : 0;
        snk_stall_pct = (phase == PH_SNK_STALL) ? 83 : (phase == PH_BOTH) ? 36 : 0;
    end

    // Receiver; one long hold-off in the first random block fills the block
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!pressed && i_rst_n && in_random && in_ch.valid && cycles > 3000) begin
            pressed <= 1'b1;
            stall_left <= 700;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_item(input logic kind, input logic [31:0] x, y, z);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {kind, x, y, z};
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic write_dir(input logic [vrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'h7FFF0000 + $urandom_range(65535);
            default: return 32'($signed($urandom_range(12800000)) - 6400000);
        endcase
    endfunction

    task automatic random_block(input int n);
        int k;
        k = 0;
        while (k < n) begin
            send_item(1'b1, pick_pos(), pick_pos(), pick_pos());
            k++;
            for (int s = $urandom_range(8); s > 0 && k < n; s--) begin
                send_item($urandom_range(9) == 0, $urandom, $urandom, $urandom);
                k++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero direction leaves position unchanged
        send_item(1'b1, 32'h00018000, 32'hFFFE8000, 32'h0);
        send_item(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();
        write_dir(vrs_pkg::REG_DIR_X, 16'h1000);
        write_dir(vrs_pkg::REG_DIR_Y, 16'hF000);
        write_dir(vrs_pkg::REG_DIR_Z, 16'h0800);
        write_dir(REG_NONE, 16'hFFFF);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'hFFFF4000, 32'h0002C000, 32'hFFFFFFFF);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        drain();
        // extremes and saturation at the top and bottom of range
        write_dir(vrs_pkg::REG_DIR_X, 16'h7FFF);
        write_dir(vrs_pkg::REG_DIR_Y, 16'h8000);
        write_dir(vrs_pkg::REG_DIR_Z, 16'h0001);
        send_item(1'b1, 32'h7FFF0000, 32'h80010000, 32'h00000001);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        send_item(1'b1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_item(1'b0, 32'h0, 32'h0, 32'h0);
        drain();

        // random phases, fresh direction settings between them
        in_random <= 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            phase <= t_phase'(ph % 4);
            write_dir(vrs_pkg::REG_DIR_X, pick_dir());
            write_dir(vrs_pkg::REG_DIR_Y, pick_dir());
            write_dir(vrs_pkg::REG_DIR_Z, pick_dir());
            if ($urandom_range(3) == 0) write_dir(REG_NONE, 16'($urandom));
            random_block(100);
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
